// File: hw/rtl/chp_pkg.sv
`default_nettype none
package chp_pkg;

  // One base colour request
  typedef struct packed {
    logic [7:0] base_red;
    logic [7:0] base_green;
    logic [7:0] base_blue;
    logic [7:0] base_alpha;
  } in_t;

  // One palette entry
  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic [4:0] entry_index;
    logic       is_last;
  } out_t;

  // Configuration registers
  typedef struct packed {
    logic [3:0]  mode;
    logic [5:0]  color_count;
    logic [16:0] spread;
    logic [15:0] sat_scale;
    logic [15:0] val_scale;
  } cfg_t;

  // One classified entry handed from front to back
  typedef struct packed {
    in_t         base;
    logic [15:0] hue_off;
    logic [16:0] frac;
    logic [7:0]  target;
    logic [4:0]  entry_index;
    logic        is_last;
  } job_t;

  // Register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPREAD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_SCALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VAL_SCALE = 3'd4;

  // Harmony modes
  localparam logic [3:0] MODE_COMPL    = 4'd0;
  localparam logic [3:0] MODE_SPLIT    = 4'd1;
  localparam logic [3:0] MODE_ANALOG   = 4'd2;
  localparam logic [3:0] MODE_TRIAD    = 4'd3;
  localparam logic [3:0] MODE_SQUARE   = 4'd4;
  localparam logic [3:0] MODE_RECT     = 4'd5;
  localparam logic [3:0] MODE_MONO     = 4'd6;
  localparam logic [3:0] MODE_SHADES   = 4'd7;
  localparam logic [3:0] MODE_TINTS    = 4'd8;
  localparam logic [3:0] MODE_TONES    = 4'd9;
  localparam logic [3:0] MODE_COMPOUND = 4'd10;
  localparam logic [3:0] MODE_GOLDEN   = 4'd11;

  localparam logic [16:0] ONE16       = 17'd65536;
  localparam logic [31:0] GOLDEN_STEP = 32'h9E3779B9;

  // Shared divider geometry
  localparam int DIV_NUM_W = 28;
  localparam int DIV_DEN_W = 11;

  // Front to back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

endpackage
`default_nettype wire

// File: hw/rtl/chp_div.sv
`default_nettype none
module chp_div import chp_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [DIV_NUM_W-1:0] numer,
  input  wire logic [DIV_DEN_W-1:0] denom,
  output logic                      done,
  output logic [DIV_NUM_W-1:0]      quot
);

  localparam int CW = $clog2(DIV_NUM_W + 1);

  logic                 run;
  logic [CW-1:0]        steps;
  logic [DIV_DEN_W:0]   rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_DEN_W:0]   rem_sh;
  logic                 fits;

  // One restoring step per cycle, quotient shifts in where the dividend leaves
  assign rem_sh = {rem[DIV_DEN_W-1:0], quot[DIV_NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      run   <= 1'b0;
      steps <= '0;
    end else if (start) begin
      run   <= 1'b1;
      steps <= '0;
      rem   <= '0;
      den   <= denom;
      quot  <= numer;
    end else if (run) begin
      rem   <= fits ? rem_sh - {1'b0, den} : rem_sh;
      quot  <= {quot[DIV_NUM_W-2:0], fits};
      steps <= steps + 1'b1;
      if (steps == CW'(DIV_NUM_W - 1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/chp_queue.sv
`default_nettype none
module chp_queue import chp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t data_in,
  input  wire logic pop,
  output job_t      data_out,
  output logic      full,
  output logic      empty
);

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full     = fill == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign empty    = fill == '0;
  assign data_out = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= data_in;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/chp_front.sv
`default_nettype none
module chp_front import chp_pkg::*; #(
  parameter int MAX_COLORS = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start_acc,
  input  wire in_t  base,
  input  wire cfg_t cfg,
  output logic      busy,
  input  wire logic q_full,
  output logic      q_push,
  output job_t      q_data
);

  localparam int NW = $clog2(MAX_COLORS + 1);
  localparam int IW = (NW > 3) ? NW : 3;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_PUSH = 2'd3;

  logic [1:0]    state;
  logic [IW-1:0] idx;
  logic [IW-1:0] n;
  logic [IW-1:0] cnt;
  in_t           base_r;
  job_t          job;
  logic          div_frac_r;

  logic [IW-1:0] n_start;
  logic [IW-1:0] cnt_start;
  logic [16:0]   sp;
  logic [IW-1:0] m;
  logic [IW-1:0] na;
  logic [IW:0]   two_i;
  logic [IW:0]   dev;
  logic [15:0]   calc_off;
  logic [16:0]   calc_frac;
  logic [7:0]    calc_tgt;
  logic          need_div;
  logic          div_frac;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic          div_done;
  logic [DIV_NUM_W-1:0] div_quot;
  logic [37:0]   gold;

  // Numerator of a centred hue window offset, rounding term included
  function automatic logic [DIV_NUM_W-1:0] win_num(input logic [IW-1:0] i,
                                                   input logic [IW-1:0] mm,
                                                   input logic [16:0] s);
    logic [DIV_NUM_W-1:0] acc;
    acc = DIV_NUM_W'(2) * DIV_NUM_W'(i) * DIV_NUM_W'(s)
        + DIV_NUM_W'(mm) * (DIV_NUM_W'(131072) - DIV_NUM_W'(s)) + DIV_NUM_W'(mm);
    return acc;
  endfunction

  assign sp = (cfg.spread > ONE16) ? ONE16 : cfg.spread;

  // Entry count at request time
  always_comb begin
    if (cfg.color_count == '0)               n_start = IW'(1);
    else if (32'(cfg.color_count) > MAX_COLORS) n_start = IW'(MAX_COLORS);
    else                                     n_start = IW'(cfg.color_count);
    case (cfg.mode)
      MODE_COMPL:    cnt_start = IW'(2);
      MODE_SPLIT:    cnt_start = IW'(3);
      MODE_TRIAD:    cnt_start = IW'(3);
      MODE_SQUARE:   cnt_start = IW'(4);
      MODE_RECT:     cnt_start = IW'(4);
      MODE_COMPOUND: cnt_start = (n_start > IW'(1)) ? n_start : IW'(2);
      default:       cnt_start = n_start;
    endcase
  end

  // Classify the current entry: direct offset or a division to run
  always_comb begin
    m         = n - 1'b1;
    na        = (n > IW'(1)) ? n - 1'b1 : IW'(1);
    two_i     = {idx, 1'b0};
    dev       = (two_i < {1'b0, m}) ? {1'b0, m} - two_i : two_i - {1'b0, m};
    gold      = 38'(idx) * 38'(GOLDEN_STEP) + 38'd32768;
    calc_off  = '0;
    calc_frac = '0;
    calc_tgt  = 8'd255;
    need_div  = 1'b0;
    div_frac  = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (cfg.mode)
      MODE_COMPL:  calc_off = (idx == '0) ? 16'd0 : 16'd32768;
      MODE_SPLIT: begin
        if (idx == IW'(1))      calc_off = 16'(17'd32768 - sp);
        else if (idx == IW'(2)) calc_off = 16'(17'd32768 + sp);
      end
      MODE_TRIAD: begin
        if (idx == IW'(1))      calc_off = 16'd21845;
        else if (idx == IW'(2)) calc_off = 16'd43691;
      end
      MODE_SQUARE: calc_off = 16'(32'(idx) << 14);
      MODE_RECT: begin
        if (idx == IW'(1))      calc_off = sp[15:0];
        else if (idx == IW'(2)) calc_off = 16'd32768;
        else if (idx == IW'(3)) calc_off = 16'(17'd32768 + sp);
      end
      MODE_ANALOG: begin
        if (n > IW'(1)) begin
          need_div = 1'b1;
          div_num  = win_num(idx, m, sp);
          div_den  = DIV_DEN_W'({m, 1'b0});
        end
      end
      MODE_COMPOUND: begin
        if (idx >= na) calc_off = 16'd32768;
        else if (na > IW'(1)) begin
          need_div = 1'b1;
          div_num  = win_num(idx, na - 1'b1, sp);
          div_den  = DIV_DEN_W'({na - 1'b1, 1'b0});
        end
      end
      MODE_GOLDEN: calc_off = gold[31:16];
      MODE_MONO: begin
        if (m != '0) begin
          need_div = 1'b1;
          div_frac = 1'b1;
          div_num  = DIV_NUM_W'(dev) * DIV_NUM_W'(sp) + DIV_NUM_W'(m >> 1);
          div_den  = DIV_DEN_W'(m);
          if (two_i < {1'b0, m}) calc_tgt = 8'd0;
        end
      end
      MODE_SHADES, MODE_TINTS, MODE_TONES: begin
        if (m != '0) begin
          need_div = 1'b1;
          div_frac = 1'b1;
          div_num  = DIV_NUM_W'(idx) * DIV_NUM_W'(sp) + DIV_NUM_W'(m >> 1);
          div_den  = DIV_DEN_W'(m);
        end
        if (cfg.mode == MODE_SHADES)     calc_tgt = 8'd0;
        else if (cfg.mode == MODE_TONES) calc_tgt = 8'd128;
      end
      default: calc_off = '0;
    endcase
  end

  chp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_CALC && need_div),
    .numer (div_num),
    .denom (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign busy   = state != S_IDLE;
  assign q_push = (state == S_PUSH) && !q_full;
  assign q_data = job;

  // Entry sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start_acc && cfg.mode <= MODE_GOLDEN) begin
            base_r <= base;
            n      <= n_start;
            cnt    <= cnt_start;
            idx    <= '0;
            state  <= S_CALC;
          end
        end
        S_CALC: begin
          job.base        <= base_r;
          job.hue_off     <= calc_off;
          job.frac        <= calc_frac;
          job.target      <= calc_tgt;
          job.entry_index <= 5'(idx);
          job.is_last     <= idx == cnt - 1'b1;
          div_frac_r      <= div_frac;
          state           <= need_div ? S_WAIT : S_PUSH;
        end
        S_WAIT: begin
          if (div_done) begin
            if (div_frac_r) job.frac    <= div_quot[16:0];
            else            job.hue_off <= div_quot[15:0];
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!q_full) begin
            idx   <= idx + 1'b1;
            state <= (idx == cnt - 1'b1) ? S_IDLE : S_CALC;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/chp_back.sv
`default_nettype none
module chp_back import chp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_empty,
  output logic      q_pop,
  input  wire job_t q_data,
  input  wire cfg_t cfg,
  output logic      busy,
  output out_t      result,
  output logic      result_valid
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BLEND = 3'd1;
  localparam logic [2:0] S_HSV   = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_SCALE = 3'd4;
  localparam logic [2:0] S_PQT1  = 3'd5;
  localparam logic [2:0] S_PQT2  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]  state;
  job_t        job;
  logic [7:0]  br, bg, bb, ba;
  logic [16:0] v, s, s2, v2;
  logic        mx_zero, d_zero;
  logic [15:0] h;
  logic [2:0]  sector;
  logic [15:0] f;
  logic [16:0] sf, s1f, p;
  logic [16:0] rr, gg, bbv;

  logic [7:0]  mx, mn, d;
  logic [10:0] hnum;
  logic [DIV_NUM_W-1:0] s_num, h_num;
  logic [DIV_DEN_W-1:0] s_den, h_den;
  logic        s_done, h_done;
  logic [DIV_NUM_W-1:0] s_quot, h_quot;
  logic [18:0] h6;
  logic [16:0] qv, tv;

  function automatic logic [7:0] blend_ch(input logic [7:0] c, input logic [7:0] tgt,
                                          input logic [16:0] t);
    logic [25:0] acc;
    acc = 26'(c) * 26'(ONE16 - t) + 26'(tgt) * 26'(t) + 26'd32768;
    return acc[23:16];
  endfunction

  function automatic logic [7:0] to8(input logic [16:0] x);
    logic [24:0] acc;
    acc = 25'(x) * 25'd255 + 25'd32768;
    return acc[23:16];
  endfunction

  function automatic logic [16:0] mul_r16(input logic [16:0] a, input logic [16:0] b);
    logic [33:0] acc;
    acc = 34'(a) * 34'(b) + 34'd32768;
    return acc[32:16];
  endfunction

  function automatic logic [16:0] scale_clamp(input logic [16:0] x, input logic [15:0] k);
    logic [32:0] acc;
    acc = 33'(x) * 33'(k) + 33'd8192;
    return (acc[32:14] > 19'(ONE16)) ? ONE16 : acc[30:14];
  endfunction

  // Channel extremes and hue numerator of the blended colour
  always_comb begin
    mx = br;
    if (bg > mx) mx = bg;
    if (bb > mx) mx = bb;
    mn = br;
    if (bg < mn) mn = bg;
    if (bb < mn) mn = bb;
    d = mx - mn;
    if (br >= bg && br >= bb) begin
      hnum = (bg >= bb) ? 11'(bg - bb) : 11'(6) * 11'(d) - 11'(bb - bg);
    end else if (bg >= bb) begin
      hnum = 11'(bb) + 11'(2) * 11'(d) - 11'(br);
    end else begin
      hnum = 11'(br) + 11'(4) * 11'(d) - 11'(bg);
    end
    s_num = DIV_NUM_W'({d, 16'd0}) + DIV_NUM_W'(mx >> 1);
    s_den = DIV_DEN_W'(mx);
    h_num = DIV_NUM_W'({hnum, 16'd0}) + DIV_NUM_W'(3) * DIV_NUM_W'(d);
    h_den = DIV_DEN_W'(6) * DIV_DEN_W'(d);
  end

  chp_div u_sdiv (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_HSV),
    .numer (s_num),
    .denom (s_den),
    .done  (s_done),
    .quot  (s_quot)
  );

  chp_div u_hdiv (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_HSV),
    .numer (h_num),
    .denom (h_den),
    .done  (h_done),
    .quot  (h_quot)
  );

  assign h6 = 19'(h) * 19'd6;
  assign qv = mul_r16(v2, ONE16 - sf);
  assign tv = mul_r16(v2, ONE16 - s1f);

  assign busy  = state != S_IDLE;
  assign q_pop = (state == S_IDLE) && !q_empty;

  // Per-entry sequence: blend, HSV, scale, back to RGB
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            job   <= q_data;
            state <= S_BLEND;
          end
        end
        S_BLEND: begin
          br    <= blend_ch(job.base.base_red,   job.target, job.frac);
          bg    <= blend_ch(job.base.base_green, job.target, job.frac);
          bb    <= blend_ch(job.base.base_blue,  job.target, job.frac);
          ba    <= blend_ch(job.base.base_alpha, 8'd255,     job.frac);
          state <= S_HSV;
        end
        S_HSV: begin
          v       <= {mx, 8'd0} + 17'(mx) + 17'(mx[7]);
          mx_zero <= mx == '0;
          d_zero  <= d == '0;
          state   <= S_WAIT;
        end
        S_WAIT: begin
          if (s_done && h_done) begin
            s     <= mx_zero ? 17'd0 : s_quot[16:0];
            h     <= (d_zero ? 16'd0 : h_quot[15:0]) + job.hue_off;
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          s2     <= scale_clamp(s, cfg.sat_scale);
          v2     <= scale_clamp(v, cfg.val_scale);
          sector <= h6[18:16];
          f      <= h6[15:0];
          state  <= S_PQT1;
        end
        S_PQT1: begin
          sf    <= mul_r16(s2, {1'b0, f});
          s1f   <= mul_r16(s2, ONE16 - {1'b0, f});
          p     <= mul_r16(v2, ONE16 - s2);
          state <= S_PQT2;
        end
        S_PQT2: begin
          case (sector)
            3'd0:    begin rr <= v2; gg <= tv; bbv <= p;  end
            3'd1:    begin rr <= qv; gg <= v2; bbv <= p;  end
            3'd2:    begin rr <= p;  gg <= v2; bbv <= tv; end
            3'd3:    begin rr <= p;  gg <= qv; bbv <= v2; end
            3'd4:    begin rr <= tv; gg <= p;  bbv <= v2; end
            default: begin rr <= v2; gg <= p;  bbv <= qv; end
          endcase
          state <= S_OUT;
        end
        S_OUT: begin
          result.out_red     <= to8(rr);
          result.out_green   <= to8(gg);
          result.out_blue    <= to8(bbv);
          result.out_alpha   <= ba;
          result.entry_index <= job.entry_index;
          result.is_last     <= job.is_last;
          result_valid       <= 1'b1;
          state              <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/color_harmony_palette_generator.sv
`default_nettype none
// Palette generator: a request on start (taken when busy is low) carries one
// RGBA base colour; the block returns 1..MAX_COLORS palette entries, one per
// result_valid pulse, the final one flagged by is_last. Results cannot be
// held off, so the consumer must take every pulse. The back end's cost per
// entry is set by the 28-step shift-subtract dividers that redo the HSV
// conversion per entry; the front end works out offsets and blend fractions
// with its own divider in the shadow of that. busy stays high until the
// last entry has left; a request in a mode without meaning yields no
// entries.
module color_harmony_palette_generator import chp_pkg::*; #(
  parameter int MAX_COLORS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_t                   base,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output out_t                       result,
  output logic                       result_valid
);

  cfg_t cfg;
  logic front_busy, back_busy;
  logic q_push, q_pop, q_full, q_empty;
  job_t q_in, q_out;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode        <= MODE_COMPL;
      cfg.color_count <= 6'd5;
      cfg.spread      <= 17'd10923;
      cfg.sat_scale   <= 16'd16384;
      cfg.val_scale   <= 16'd16384;
    end else if (wr_en) begin
      case (wr_index)
        REG_MODE:      cfg.mode        <= wr_data[3:0];
        REG_COUNT:     cfg.color_count <= wr_data[5:0];
        REG_SPREAD:    cfg.spread      <= wr_data;
        REG_SAT_SCALE: cfg.sat_scale   <= wr_data[15:0];
        REG_VAL_SCALE: cfg.val_scale   <= wr_data[15:0];
        default:       cfg.mode        <= cfg.mode;
      endcase
    end
  end

  assign busy = front_busy || !q_empty || back_busy;

  chp_front #(.MAX_COLORS(MAX_COLORS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .start_acc (start && !busy),
    .base      (base),
    .cfg       (cfg),
    .busy      (front_busy),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  chp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .data_in  (q_in),
    .pop      (q_pop),
    .data_out (q_out),
    .full     (q_full),
    .empty    (q_empty)
  );

  chp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .q_data       (q_out),
    .cfg          (cfg),
    .busy         (back_busy),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule
`default_nettype wire

// File: hw/rtl/chp_checker.sv
`default_nettype none
module chp_checker import chp_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic busy,
  input wire out_t result,
  input wire logic result_valid
);

  // An idle block has nothing in flight to emit
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy |=> !result_valid)
    else $error("result after idle cycle");

  // More entries are owed after a non-final one
  a_run_open: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.is_last |-> busy)
    else $error("palette run closed early");

  // Entries are never back to back
  a_spaced: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("entries too close");

  // Reset leaves the block idle
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !busy && !result_valid)
    else $error("busy after reset");

endmodule

bind color_harmony_palette_generator chp_checker u_chp_checker (.*);
`default_nettype wire
